### sv/mfr_pkg.sv
`timescale 1ns / 1ps
package mfr_pkg;

  localparam int MAX_LINES  = 8;
  localparam int LINE_DEPTH = 4096;
  localparam int LINE_W     = $clog2(MAX_LINES);
  localparam int POS_W      = $clog2(LINE_DEPTH);
  localparam int ADDR_W     = LINE_W + POS_W;
  localparam int MEM_DEPTH  = MAX_LINES * LINE_DEPTH;
  localparam int ECHO_W     = 41;
  localparam int SUM_W      = 44;
  localparam int PROD_W     = 61;
  localparam int MAG_W      = 60;
  localparam int DEN_W      = 20;
  localparam int DIV_STEPS  = MAG_W / 2;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_NUM    = 2'd1;
  localparam logic [1:0] CFG_DECAY  = 2'd2;
  localparam logic [1:0] CFG_UNIT   = 2'd3;

  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_ACC,
    ST_MUL,
    ST_NUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ECHO_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_stat_t;

endpackage

### sv/multitap_feedback_reverb_unit.sv
`timescale 1ns / 1ps
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------
// in       | in_valid / in_ready   | sample_in[31:0], block_end_in
// out      | out_valid / out_ready | sample_out[31:0], block_end_out
// cfg      | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[31:0]
//
// the time a sample takes depends on n, the number of active lines (at most
// eight); the line walk through the echo memory (one read, one write port)
// and the 2-bit-per-cycle divider set it
// after reset a clearing pass zeroes all 32768 echo memory entries, one entry
// per cycle; in_ready stays low meanwhile, config transfers are always taken
// a finished sample waits in the output register; the next sample is taken
// while it waits, and the block only stalls at its end if the old one is
// still not taken
module multitap_feedback_reverb_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_in,
  input  logic        block_end_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sample_out,
  output logic        block_end_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  mfr_pkg::state_t state, state_next;

  // configuration registers
  logic [1:0]  fmt_cfg;
  logic [3:0]  num_cfg;
  logic [15:0] decay_cfg;
  logic [9:0]  unit_cfg;

  // per-sample working registers
  logic [1:0]                        fmt_r;
  logic [3:0]                        n_r;
  logic [9:0]                        unit_r;
  logic [15:0]                       decay_r;
  logic signed [31:0]                x_r;
  logic                              bend_r;
  logic [3:0]                        line_r;
  logic [12:0]                       len_acc;
  logic signed [mfr_pkg::SUM_W-1:0]  sum_r;
  logic signed [mfr_pkg::PROD_W-1:0] prod_r;
  logic signed [mfr_pkg::PROD_W-1:0] num_r;
  logic [mfr_pkg::DEN_W-1:0]         den_r;
  logic [mfr_pkg::ECHO_W-1:0]        e_r;
  logic [mfr_pkg::POS_W-1:0]         pos_r [mfr_pkg::MAX_LINES];
  logic [mfr_pkg::ADDR_W:0]          clr_cnt;

  mfr_pkg::ram_ctrl_t          ram_ctrl;
  logic [mfr_pkg::ECHO_W-1:0]  rd_data;
  mfr_pkg::div_ctrl_t          div_ctrl;
  mfr_pkg::div_stat_t          div_stat;

  // combinational helpers
  logic [mfr_pkg::LINE_W-1:0] line_idx;
  logic [12:0]                len_sat;
  logic [mfr_pkg::POS_W-1:0]  pos_cur;
  logic [mfr_pkg::POS_W-1:0]  pos_fix;
  logic [12:0]                pos_inc;
  logic [mfr_pkg::POS_W-1:0]  pos_adv;
  logic                       line_last;
  logic                       num_neg;
  logic [mfr_pkg::PROD_W-1:0] num_abs;
  logic [mfr_pkg::ECHO_W-1:0] q_lo;
  logic signed [41:0]         out_t;
  logic signed [41:0]         out_adj;
  logic signed [33:0]         out_v;
  logic [31:0]                out_word;
  logic                       out_free;

  assign cfg_ready = 1'b1;

  assign line_idx  = line_r[mfr_pkg::LINE_W-1:0];
  assign len_sat   = (len_acc > 13'(mfr_pkg::LINE_DEPTH)) ? 13'(mfr_pkg::LINE_DEPTH) : len_acc;
  assign pos_cur   = pos_r[line_idx];
  // a position beyond a shortened line falls back to the line start
  assign pos_fix   = ({1'b0, pos_cur} >= len_sat) ? '0 : pos_cur;
  assign pos_inc   = {1'b0, pos_cur} + 13'd1;
  assign pos_adv   = (pos_inc >= len_sat) ? '0 : pos_inc[mfr_pkg::POS_W-1:0];
  assign line_last = ((line_r + 4'd1) == n_r);
  assign num_neg   = num_r[mfr_pkg::PROD_W-1];
  assign num_abs   = num_neg ? (-num_r) : num_r;
  assign q_lo      = div_stat.quotient[mfr_pkg::ECHO_W-1:0];
  assign out_free  = !out_valid || out_ready;

  // back to sample units: restore offset, truncate toward zero, saturate
  always_comb begin
    out_t   = {e_r[mfr_pkg::ECHO_W-1], e_r} + ((fmt_r == mfr_pkg::FMT_U8) ? 42'sd32768 : 42'sd0);
    out_adj = out_t + (out_t[41] ? 42'sd255 : 42'sd0);
    out_v   = out_adj[41:8];
    unique case (fmt_r)
      mfr_pkg::FMT_U8: begin
        if (out_v < 34'sd0) out_word = 32'd0;
        else if (out_v > 34'sd255) out_word = 32'd255;
        else out_word = {24'd0, out_v[7:0]};
      end
      mfr_pkg::FMT_S16: begin
        if (out_v < -34'sd32768) out_word = 32'h0000_8000;
        else if (out_v > 34'sd32767) out_word = 32'h0000_7fff;
        else out_word = {16'd0, out_v[15:0]};
      end
      default: begin
        if (out_v < -34'sd2147483648) out_word = 32'h8000_0000;
        else if (out_v > 34'sd2147483647) out_word = 32'h7fff_ffff;
        else out_word = out_v[31:0];
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, input handshake, memory and divider control
  always_comb begin
    state_next        = state;
    in_ready          = 1'b0;
    ram_ctrl          = '0;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = num_abs[mfr_pkg::MAG_W-1:0];
    div_ctrl.divisor  = den_r;
    unique case (state)
      mfr_pkg::ST_CLEAR: begin
        ram_ctrl.wr_en   = 1'b1;
        ram_ctrl.wr_addr = clr_cnt[mfr_pkg::ADDR_W-1:0];
        if (clr_cnt == (mfr_pkg::ADDR_W+1)'(mfr_pkg::MEM_DEPTH - 1)) begin
          state_next = mfr_pkg::ST_IDLE;
        end
      end
      mfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (num_cfg == 4'd0) ? mfr_pkg::ST_MUL : mfr_pkg::ST_RD_ADDR;
        end
      end
      mfr_pkg::ST_RD_ADDR: begin
        ram_ctrl.rd_en   = 1'b1;
        ram_ctrl.rd_addr = {line_idx, pos_fix};
        state_next       = mfr_pkg::ST_RD_ACC;
      end
      mfr_pkg::ST_RD_ACC: begin
        state_next = line_last ? mfr_pkg::ST_MUL : mfr_pkg::ST_RD_ADDR;
      end
      mfr_pkg::ST_MUL: begin
        state_next = mfr_pkg::ST_NUM;
      end
      mfr_pkg::ST_NUM: begin
        state_next = mfr_pkg::ST_DIV_GO;
      end
      mfr_pkg::ST_DIV_GO: begin
        div_ctrl.start = 1'b1;
        state_next     = mfr_pkg::ST_DIV_WAIT;
      end
      mfr_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = (n_r == 4'd0) ? mfr_pkg::ST_OUT : mfr_pkg::ST_WRITE;
        end
      end
      mfr_pkg::ST_WRITE: begin
        ram_ctrl.wr_en   = 1'b1;
        ram_ctrl.wr_addr = {line_idx, pos_cur};
        ram_ctrl.wr_data = e_r;
        if (line_last) begin
          state_next = mfr_pkg::ST_OUT;
        end
      end
      mfr_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = mfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mfr_pkg::ST_IDLE;
      end
    endcase
  end

  // config writes, clear counter, positions, output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_cfg   <= mfr_pkg::FMT_S16;
      num_cfg   <= 4'd4;
      decay_cfg <= 16'd32768;
      unit_cfg  <= 10'd512;
      out_valid <= 1'b0;
      clr_cnt   <= '0;
      for (int i = 0; i < mfr_pkg::MAX_LINES; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mfr_pkg::CFG_FORMAT: fmt_cfg   <= cfg_data[1:0];
          mfr_pkg::CFG_NUM:    num_cfg   <= cfg_data[3:0];
          mfr_pkg::CFG_DECAY:  decay_cfg <= cfg_data[15:0];
          mfr_pkg::CFG_UNIT:   unit_cfg  <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (state == mfr_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == mfr_pkg::ST_RD_ADDR) begin
        pos_r[line_idx] <= pos_fix;
      end
      if (state == mfr_pkg::ST_WRITE) begin
        pos_r[line_idx] <= pos_adv;
      end
      // a new result replaces one taken in the same cycle
      if (state == mfr_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      mfr_pkg::ST_IDLE: begin
        if (in_valid) begin
          fmt_r   <= (fmt_cfg == 2'd3) ? mfr_pkg::FMT_S32 : fmt_cfg;
          n_r     <= (num_cfg > 4'(mfr_pkg::MAX_LINES)) ? 4'(mfr_pkg::MAX_LINES) : num_cfg;
          unit_r  <= (unit_cfg == 10'd0) ? 10'd1 : unit_cfg;
          len_acc <= {3'd0, ((unit_cfg == 10'd0) ? 10'd1 : unit_cfg)};
          decay_r <= decay_cfg;
          bend_r  <= block_end_in;
          line_r  <= '0;
          sum_r   <= '0;
          if (fmt_cfg == mfr_pkg::FMT_U8) begin
            x_r <= $signed({24'd0, sample_in[7:0]}) - 32'sd128;
          end else if (fmt_cfg == mfr_pkg::FMT_S16) begin
            x_r <= $signed({{16{sample_in[15]}}, sample_in[15:0]});
          end else begin
            x_r <= $signed(sample_in);
          end
        end
      end
      mfr_pkg::ST_RD_ACC: begin
        sum_r   <= sum_r + $signed({{3{rd_data[mfr_pkg::ECHO_W-1]}}, rd_data});
        line_r  <= line_r + 4'd1;
        len_acc <= len_acc + {3'd0, unit_r};
      end
      mfr_pkg::ST_MUL: begin
        prod_r <= $signed({1'b0, decay_r}) * sum_r;
        den_r  <= 20'h10000 + ({16'd0, n_r} * {4'd0, decay_r});
      end
      mfr_pkg::ST_NUM: begin
        num_r <= $signed({{5{x_r[31]}}, x_r, 24'd0}) + prod_r;
      end
      mfr_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          e_r     <= num_neg ? (-q_lo) : q_lo;
          line_r  <= '0;
          len_acc <= {3'd0, unit_r};
        end
      end
      mfr_pkg::ST_WRITE: begin
        line_r  <= line_r + 4'd1;
        len_acc <= len_acc + {3'd0, unit_r};
      end
      mfr_pkg::ST_OUT: begin
        if (out_free) begin
          sample_out    <= out_word;
          block_end_out <= bend_r;
        end
      end
      default: ;
    endcase
  end

  mfr_echo_ram u_ram (
    .clk     (clk),
    .ctrl    (ram_ctrl),
    .rd_data (rd_data)
  );

  mfr_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat)
  );

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != mfr_pkg::ST_IDLE))
    else $error("sequencer stayed idle after input transfer");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_ctrl.wr_en |-> (state == mfr_pkg::ST_CLEAR || state == mfr_pkg::ST_WRITE))
    else $error("echo memory written outside clear or write-back");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == mfr_pkg::ST_DIV_WAIT))
    else $error("divider finished while sequencer not waiting");

  a_line_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == mfr_pkg::ST_RD_ADDR || state == mfr_pkg::ST_WRITE) |-> (line_r < n_r))
    else $error("line index beyond active lines");
`endif

endmodule

### sv/mfr_echo_ram.sv
`timescale 1ns / 1ps
module mfr_echo_ram (
  input  logic                             clk,
  input  mfr_pkg::ram_ctrl_t               ctrl,
  output logic [mfr_pkg::ECHO_W-1:0]       rd_data
);

  logic [mfr_pkg::ECHO_W-1:0] mem [mfr_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.rd_addr];
    end
  end

endmodule

### sv/mfr_divider.sv
`timescale 1ns / 1ps
module mfr_divider (
  input  logic               clk,
  input  logic               rst,
  input  mfr_pkg::div_ctrl_t ctrl,
  output mfr_pkg::div_stat_t stat
);

  logic [mfr_pkg::DEN_W-1:0]  rem;
  logic [mfr_pkg::DEN_W-1:0]  den;
  logic [mfr_pkg::MAG_W-1:0]  quo;
  logic [mfr_pkg::DCNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [mfr_pkg::DEN_W-1:0]  rem_next;
  logic [mfr_pkg::MAG_W-1:0]  quo_next;

  // two restoring steps per cycle
  always_comb begin
    logic [mfr_pkg::DEN_W:0] t;
    rem_next = rem;
    quo_next = quo;
    t = '0;
    for (int s = 0; s < 2; s++) begin
      t = {rem_next, quo_next[mfr_pkg::MAG_W-1]};
      quo_next = {quo_next[mfr_pkg::MAG_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        quo_next[0] = 1'b1;
      end
      rem_next = t[mfr_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == mfr_pkg::DCNT_W'(mfr_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= ctrl.dividend;
      den <= ctrl.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign stat.busy     = busy;
  assign stat.done     = done;
  assign stat.quotient = quo;

endmodule
